@@ src/wsrd_pkg.sv @@
// Shared types and constants for the work-stealing ring deque.
// No dependencies; used by every module of the block except wsrd_ram.
`default_nettype none
package wsrd_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 8;
  localparam int WM_W   = 8;
  localparam int BL_W   = 6;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 8;

  localparam logic [WM_W-1:0] WM_RESET = WM_W'(16);
  localparam logic [BL_W-1:0] BL_RESET = BL_W'(16);

  // input action codes
  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_EMPTY = 3'd1;
  localparam logic [2:0] ACT_GRAB  = 3'd2;
  localparam logic [2:0] ACT_STEAL = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  // config register indexes
  localparam logic [CIDX_W-1:0] CFG_WATERMARK = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_BATCH     = CIDX_W'(1);

  typedef enum logic [2:0] {
    ST_GIVEN   = 3'd0,
    ST_PUSHED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_NONE    = 3'd3,
    ST_STOPPED = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic {
    CS_IDLE  = 1'b0,
    CS_BURST = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic signed [31:0] task_id;
    logic [63:0]        price_word;
    logic [63:0]        volume_word;
    logic signed [63:0] stamp;
    logic [63:0]        weight_word;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       push;
    logic       clr_req;
    logic       set_req;
    logic       stop;
    logic       pop_front;
    logic       pop_rear;
    logic       emit;
    status_t    code;
    logic       last;
    logic       help;
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             full;
    logic             low;
    logic             running;
    logic             req;
    logic [CNT_W-1:0] grab_take;
    logic [CNT_W-1:0] steal_take;
  } dq_sts_t;

endpackage
`default_nettype wire

@@ src/wsrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wsrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ src/wsrd_ctrl.sv @@
// Controller FSM: decodes actions and sequences grab / steal bursts.
// Depends on wsrd_pkg.
`default_nettype none
module wsrd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [2:0]             action,
  input  wire wsrd_pkg::dq_sts_t      sts,
  output wsrd_pkg::dq_cmd_t           cmd,
  output logic                        busy
);

  wsrd_pkg::ctrl_state_t              state_r, state_nxt;
  logic [wsrd_pkg::CNT_W-1:0]         rem_r, rem_nxt;
  logic                               front_r, front_nxt;
  logic                               help_r, help_nxt;
  logic                               help_now;
  logic                               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsrd_pkg::CS_IDLE;
      rem_r   <= '0;
      front_r <= 1'b0;
      help_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      front_r <= front_nxt;
      help_r  <= help_nxt;
    end
  end

  assign busy   = (state_r == wsrd_pkg::CS_BURST);
  assign accept = start && !busy;
  // help request fires once until a push or empty batch clears it
  assign help_now = sts.low && !sts.req && sts.running;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    front_nxt = front_r;
    help_nxt  = help_r;
    cmd       = '0;
    cmd.code  = wsrd_pkg::ST_IGNORED;

    case (state_r)
      wsrd_pkg::CS_IDLE: begin
        if (accept) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          case (action)
            wsrd_pkg::ACT_PUSH: begin
              if (sts.running) begin
                cmd.clr_req = 1'b1;
                if (sts.full) begin
                  cmd.code = wsrd_pkg::ST_DROPPED;
                end else begin
                  cmd.push = 1'b1;
                  cmd.code = wsrd_pkg::ST_PUSHED;
                end
              end
            end
            wsrd_pkg::ACT_EMPTY: begin
              if (sts.running) begin
                cmd.clr_req = 1'b1;
                cmd.code    = wsrd_pkg::ST_PUSHED;
              end
            end
            wsrd_pkg::ACT_GRAB: begin
              cmd.set_req = help_now;
              cmd.help    = help_now;
              if (sts.grab_take == '0) begin
                cmd.code = wsrd_pkg::ST_NONE;
              end else begin
                cmd.pop_front = 1'b1;
                cmd.code      = wsrd_pkg::ST_GIVEN;
                if (sts.grab_take != wsrd_pkg::CNT_W'(1)) begin
                  cmd.last  = 1'b0;
                  state_nxt = wsrd_pkg::CS_BURST;
                  rem_nxt   = sts.grab_take - wsrd_pkg::CNT_W'(1);
                  front_nxt = 1'b1;
                  help_nxt  = help_now;
                end
              end
            end
            wsrd_pkg::ACT_STEAL: begin
              if (sts.running) begin
                if (sts.steal_take == '0) begin
                  cmd.code = wsrd_pkg::ST_NONE;
                end else begin
                  cmd.pop_rear = 1'b1;
                  cmd.code     = wsrd_pkg::ST_GIVEN;
                  if (sts.steal_take != wsrd_pkg::CNT_W'(1)) begin
                    cmd.last  = 1'b0;
                    state_nxt = wsrd_pkg::CS_BURST;
                    rem_nxt   = sts.steal_take - wsrd_pkg::CNT_W'(1);
                    front_nxt = 1'b0;
                    help_nxt  = 1'b0;
                  end
                end
              end
            end
            wsrd_pkg::ACT_STOP: begin
              cmd.stop = 1'b1;
              cmd.code = wsrd_pkg::ST_STOPPED;
            end
            default: begin
              cmd.code = wsrd_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      wsrd_pkg::CS_BURST: begin
        cmd.emit      = 1'b1;
        cmd.code      = wsrd_pkg::ST_GIVEN;
        cmd.help      = help_r;
        cmd.pop_front = front_r;
        cmd.pop_rear  = !front_r;
        cmd.last      = (rem_r == wsrd_pkg::CNT_W'(1));
        rem_nxt       = rem_r - wsrd_pkg::CNT_W'(1);
        if (rem_r == wsrd_pkg::CNT_W'(1)) begin
          state_nxt = wsrd_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = wsrd_pkg::CS_IDLE;
      end
    endcase
  end

  a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> rem_r != '0)
    else $error("burst running with no entries left");

  a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pop_front && cmd.pop_rear))
    else $error("front and rear pop together");

  a_burst_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && state_nxt == wsrd_pkg::CS_BURST) |-> (cmd.emit && !cmd.last))
    else $error("burst entered on final result");

endmodule
`default_nettype wire

@@ src/wsrd_dpath.sv @@
// Datapath: ring pointers, fill count, flags, config registers, entry RAM
// and the result register. Depends on wsrd_pkg and wsrd_ram.
`default_nettype none
module wsrd_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wsrd_pkg::dq_cmd_t             cmd,
  output wsrd_pkg::dq_sts_t                  sts,
  input  wire wsrd_pkg::entry_t              in_entry,
  input  wire logic                          cfg_we,
  input  wire logic [wsrd_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [wsrd_pkg::CDAT_W-1:0]   cfg_data,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output wsrd_pkg::entry_t                   out_entry,
  output logic                               out_last,
  output logic [wsrd_pkg::FILL_W-1:0]        out_fill,
  output logic                               out_help_request
);

  localparam logic [wsrd_pkg::ADDR_W-1:0] LAST_SLOT = wsrd_pkg::ADDR_W'(wsrd_pkg::DEPTH - 1);

  logic [wsrd_pkg::ADDR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [wsrd_pkg::ADDR_W-1:0] head_inc, tail_inc, tail_dec;
  logic [wsrd_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        running_r, running_nxt, req_r, req_nxt;
  logic [wsrd_pkg::WM_W-1:0]   wm_r;
  logic [wsrd_pkg::BL_W-1:0]   bl_r;
  logic [wsrd_pkg::FILL_W-1:0] cnt_ext, bl_ext, take_ext;
  logic                        pop;

  logic                        valid_r, last_r, help_r, give_r;
  wsrd_pkg::status_t           status_r;
  logic [wsrd_pkg::FILL_W-1:0] fill_r;
  wsrd_pkg::entry_t            rd_entry;

  assign pop      = cmd.pop_front || cmd.pop_rear;
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + wsrd_pkg::ADDR_W'(1);
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + wsrd_pkg::ADDR_W'(1);
  assign tail_dec = (tail_r == '0) ? LAST_SLOT : tail_r - wsrd_pkg::ADDR_W'(1);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    running_nxt = running_r && !cmd.stop;
    req_nxt     = req_r;
    if (cmd.clr_req) req_nxt = 1'b0;
    if (cmd.set_req) req_nxt = 1'b1;
    if (cmd.push) begin
      tail_nxt  = tail_inc;
      count_nxt = count_r + wsrd_pkg::CNT_W'(1);
    end
    if (cmd.pop_front) begin
      head_nxt = head_inc;
    end
    if (cmd.pop_rear) begin
      tail_nxt = tail_dec;
    end
    if (pop) begin
      count_nxt = count_r - wsrd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      running_r <= 1'b1;
      req_r     <= 1'b0;
      wm_r      <= wsrd_pkg::WM_RESET;
      bl_r      <= wsrd_pkg::BL_RESET;
      valid_r   <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      req_r     <= req_nxt;
      valid_r   <= cmd.emit;
      if (cfg_we && cfg_index == wsrd_pkg::CFG_WATERMARK) begin
        wm_r <= cfg_data[wsrd_pkg::WM_W-1:0];
      end
      if (cfg_we && cfg_index == wsrd_pkg::CFG_BATCH) begin
        bl_r <= cfg_data[wsrd_pkg::BL_W-1:0];
      end
    end
  end

  // result sidebands travel alongside the RAM read
  always_ff @(posedge clk) begin
    status_r <= cmd.code;
    last_r   <= cmd.last;
    help_r   <= cmd.help;
    give_r   <= pop;
    fill_r   <= wsrd_pkg::FILL_W'(count_nxt);
  end

  assign cnt_ext  = wsrd_pkg::FILL_W'(count_r);
  assign bl_ext   = wsrd_pkg::FILL_W'(bl_r);
  assign take_ext = (cnt_ext < bl_ext) ? cnt_ext : bl_ext;

  assign sts.full       = (count_r == wsrd_pkg::CNT_W'(wsrd_pkg::DEPTH));
  assign sts.low        = (cnt_ext < wm_r);
  assign sts.running    = running_r;
  assign sts.req        = req_r;
  assign sts.grab_take  = take_ext[wsrd_pkg::CNT_W-1:0];
  assign sts.steal_take = count_r >> 1;

  wsrd_ram #(
    .WIDTH ($bits(wsrd_pkg::entry_t)),
    .DEPTH (wsrd_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data (in_entry),
    .rd_en   (pop),
    .rd_addr (cmd.pop_front ? head_r : tail_dec),
    .rd_data (rd_entry)
  );

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_entry        = give_r ? rd_entry : '0;
  assign out_last         = last_r;
  assign out_fill         = fill_r;
  assign out_help_request = help_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= wsrd_pkg::CNT_W'(wsrd_pkg::DEPTH))
    else $error("fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty deque");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full && !pop)
    else $error("push into full deque or with pop");

  a_give_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r && status_r == wsrd_pkg::ST_GIVEN)
    else $error("popped entry not presented");

endmodule
`default_nettype wire

@@ src/work_stealing_ring_deque_unit.sv @@
// Top level of the work-stealing ring deque.
// Depends on wsrd_pkg, wsrd_ctrl, wsrd_dpath (and wsrd_ram below it).
//
// Usage:
// - Command channel: an action is taken at a clock edge with start high and
//   busy low. Push carries the entry fields; other actions ignore them.
// - Result channel: each result is shown for one cycle with out_valid high;
//   the receiver cannot stall it, so results must be taken as they come.
//   out_last marks the final result of an action.
// - Config channel: cfg_valid/cfg_ready with cfg_index (0 low watermark,
//   1 batch limit) and cfg_data; a transfer happens when both are high.
//   Write only while no action is in flight.
// - The first result appears in the cycle after the action is taken.
// - Throughput: push, empty batch, stop and grabs/steals giving at most one
//   entry never raise busy, so a new action can follow every cycle. A grab
//   or steal that gives more entries keeps busy high until its last entry
//   is out, one entry a cycle, limited by the single read port of the RAM.
// - Reset (rst_n low, synchronous): deque empty, running, no help request
//   outstanding, watermark 16, batch limit 16. Entry storage is not cleared;
//   only written slots are ever read.
`default_nettype none
module work_stealing_ring_deque_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_action,
  input  wire logic signed [31:0]            in_task_id,
  input  wire logic [63:0]                   in_price_word,
  input  wire logic [63:0]                   in_volume_word,
  input  wire logic signed [63:0]            in_stamp,
  input  wire logic [63:0]                   in_weight_word,
  // result channel
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic signed [31:0]                 out_task_id,
  output logic [63:0]                        out_price_word,
  output logic [63:0]                        out_volume_word,
  output logic signed [63:0]                 out_stamp,
  output logic [63:0]                        out_weight_word,
  output logic                               out_last,
  output logic [7:0]                         out_fill,
  output logic                               out_help_request,
  // config channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [wsrd_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [wsrd_pkg::CDAT_W-1:0]   cfg_data
);

  wsrd_pkg::dq_cmd_t cmd;
  wsrd_pkg::dq_sts_t sts;
  wsrd_pkg::entry_t  in_entry;
  wsrd_pkg::entry_t  out_entry;

  assign in_entry.task_id     = in_task_id;
  assign in_entry.price_word  = in_price_word;
  assign in_entry.volume_word = in_volume_word;
  assign in_entry.stamp       = in_stamp;
  assign in_entry.weight_word = in_weight_word;

  // config transfers only between bursts
  assign cfg_ready = !busy;

  wsrd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  wsrd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_entry         (in_entry),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry        (out_entry),
    .out_last         (out_last),
    .out_fill         (out_fill),
    .out_help_request (out_help_request)
  );

  assign out_task_id     = out_entry.task_id;
  assign out_price_word  = out_entry.price_word;
  assign out_volume_word = out_entry.volume_word;
  assign out_stamp       = out_entry.stamp;
  assign out_weight_word = out_entry.weight_word;

endmodule
`default_nettype wire

@@ tb/deque_result_checker.sv @@
// Result checker for the work-stealing ring deque: follows every action and
// configuration transfer, predicts the results and compares each one on arrival.
// Depends on wsrd_pkg only.
module deque_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic signed [31:0]            in_task_id,
  input  logic [63:0]                   in_price_word,
  input  logic [63:0]                   in_volume_word,
  input  logic signed [63:0]            in_stamp,
  input  logic [63:0]                   in_weight_word,
  input  logic                          out_valid,
  input  logic [2:0]                    out_status,
  input  logic signed [31:0]            out_task_id,
  input  logic [63:0]                   out_price_word,
  input  logic [63:0]                   out_volume_word,
  input  logic signed [63:0]            out_stamp,
  input  logic [63:0]                   out_weight_word,
  input  logic                          out_last,
  input  logic [7:0]                    out_fill,
  input  logic                          out_help_request,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wsrd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [wsrd_pkg::CDAT_W-1:0]   cfg_data,
  output int                            mismatch_count,
  output int unsigned                   pending_results
);
  import wsrd_pkg::*;

  typedef struct packed {
    status_t     status;
    entry_t      ent;
    logic        last;
    logic [7:0]  fill;
    logic        help;
  } deque_result_t;

  // shadow copy of the deque
  entry_t            slot_store [DEPTH];
  logic [ADDR_W-1:0] front_idx;
  logic [ADDR_W-1:0] rear_idx;
  logic [CNT_W-1:0]  held;
  logic              help_owed;
  logic              live;
  logic [WM_W-1:0]   watermark;
  logic [BL_W-1:0]   batch_cap;

  deque_result_t awaited_results [$];

  task automatic post(input status_t st, input entry_t e, input logic help, input logic fin);
    deque_result_t r;
    r.status = st;
    r.ent    = e;
    r.last   = fin;
    r.fill   = 8'(held);
    r.help   = help;
    awaited_results.push_back(r);
  endtask

  task automatic predict_action(input logic [2:0] act, input entry_t incoming);
    entry_t blank;
    logic   help;
    int     take;
    blank = '0;
    help  = 1'b0;
    case (act)
      ACT_PUSH: begin
        if (!live) begin
          post(ST_IGNORED, blank, 1'b0, 1'b1);
        end else begin
          help_owed = 1'b0;
          if (int'(held) >= DEPTH) begin
            post(ST_DROPPED, blank, 1'b0, 1'b1);
          end else begin
            slot_store[rear_idx] = incoming;
            rear_idx = ADDR_W'((int'(rear_idx) + 1) % DEPTH);
            held = held + 1'b1;
            post(ST_PUSHED, blank, 1'b0, 1'b1);
          end
        end
      end
      ACT_EMPTY: begin
        if (!live) begin
          post(ST_IGNORED, blank, 1'b0, 1'b1);
        end else begin
          help_owed = 1'b0;
          post(ST_PUSHED, blank, 1'b0, 1'b1);
        end
      end
      ACT_GRAB: begin
        if (int'(held) < int'(watermark) && !help_owed && live) begin
          help_owed = 1'b1;
          help = 1'b1;
        end
        take = (int'(held) < int'(batch_cap)) ? int'(held) : int'(batch_cap);
        if (take == 0) begin
          post(ST_NONE, blank, help, 1'b1);
        end else begin
          for (int k = 0; k < take; k++) begin
            blank = slot_store[front_idx];
            front_idx = ADDR_W'((int'(front_idx) + 1) % DEPTH);
            held = held - 1'b1;
            post(ST_GIVEN, blank, help, k == take - 1);
          end
        end
      end
      ACT_STEAL: begin
        if (!live) begin
          post(ST_IGNORED, blank, 1'b0, 1'b1);
        end else begin
          take = int'(held) / 2;
          if (take == 0) begin
            post(ST_NONE, blank, 1'b0, 1'b1);
          end else begin
            for (int k = 0; k < take; k++) begin
              rear_idx = ADDR_W'((int'(rear_idx) + DEPTH - 1) % DEPTH);
              held = held - 1'b1;
              post(ST_GIVEN, slot_store[rear_idx], 1'b0, k == take - 1);
            end
          end
        end
      end
      ACT_STOP: begin
        live = 1'b0;
        post(ST_STOPPED, blank, 1'b0, 1'b1);
      end
      default: post(ST_IGNORED, blank, 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    entry_t        incoming;
    deque_result_t want;
    if (!rst_n) begin
      front_idx = '0;
      rear_idx = '0;
      held = '0;
      help_owed = 1'b0;
      live = 1'b1;
      watermark = WM_RESET;
      batch_cap = BL_RESET;
      awaited_results.delete();
      mismatch_count = 0;
      pending_results <= 0;
    end else begin
      // results of earlier actions first; a new action's results come next cycle
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, out_status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("task_id", 64'(want.ent.task_id), 64'(out_task_id));
          check_field("price_word", want.ent.price_word, out_price_word);
          check_field("volume_word", want.ent.volume_word, out_volume_word);
          check_field("stamp", want.ent.stamp, out_stamp);
          check_field("weight_word", want.ent.weight_word, out_weight_word);
          check_field("last", 64'(want.last), 64'(out_last));
          check_field("fill", 64'(want.fill), 64'(out_fill));
          check_field("help_request", 64'(want.help), 64'(out_help_request));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WATERMARK: watermark = cfg_data;
          CFG_BATCH:     batch_cap = cfg_data[BL_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        incoming.task_id     = in_task_id;
        incoming.price_word  = in_price_word;
        incoming.volume_word = in_volume_word;
        incoming.stamp       = in_stamp;
        incoming.weight_word = in_weight_word;
        predict_action(in_action, incoming);
      end
      pending_results <= awaited_results.size();
    end
  end

endmodule

@@ tb/work_stealing_ring_deque_unit_test.sv @@
// Top of the deque testbench: clock, reset, command and config stimulus, verdict.
// Depends on wsrd_pkg, work_stealing_ring_deque_unit and deque_result_checker.
module work_stealing_ring_deque_unit_test;
  import wsrd_pkg::*;

  // cycles with no transfer on any channel before the run is declared hung
  localparam int IDLE_LIMIT = 4000;
  // action codes the block has no name for; it must answer "ignored"
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_MID   = 3'd6;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 start = 1'b0;
  logic                 busy;
  logic [2:0]           in_action = '0;
  logic signed [31:0]   in_task_id = '0;
  logic [63:0]          in_price_word = '0;
  logic [63:0]          in_volume_word = '0;
  logic signed [63:0]   in_stamp = '0;
  logic [63:0]          in_weight_word = '0;

  logic                 out_valid;
  logic [2:0]           out_status;
  logic signed [31:0]   out_task_id;
  logic [63:0]          out_price_word;
  logic [63:0]          out_volume_word;
  logic signed [63:0]   out_stamp;
  logic [63:0]          out_weight_word;
  logic                 out_last;
  logic [7:0]           out_fill;
  logic                 out_help_request;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index = '0;
  logic [CDAT_W-1:0]    cfg_data = '0;

  int                   mismatch_count;
  int unsigned          pending_results;
  int                   sender_idle_pct = 13;
  int                   quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  work_stealing_ring_deque_unit u_top (
    .clk, .rst_n,
    .start, .busy, .in_action, .in_task_id, .in_price_word, .in_volume_word,
    .in_stamp, .in_weight_word,
    .out_valid, .out_status, .out_task_id, .out_price_word, .out_volume_word,
    .out_stamp, .out_weight_word, .out_last, .out_fill, .out_help_request,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  deque_result_checker u_checker (
    .clk, .rst_n,
    .start, .busy, .in_action, .in_task_id, .in_price_word, .in_volume_word,
    .in_stamp, .in_weight_word,
    .out_valid, .out_status, .out_task_id, .out_price_word, .out_volume_word,
    .out_stamp, .out_weight_word, .out_last, .out_fill, .out_help_request,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .pending_results
  );

  // Watchdog: any transfer (command, result or config) restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Every field random, so each bit sees both values; only push stores them.
  function automatic entry_t random_entry();
    entry_t e;
    e.task_id     = $urandom;
    e.price_word  = {$urandom, $urandom};
    e.volume_word = {$urandom, $urandom};
    e.stamp       = {$urandom, $urandom};
    e.weight_word = {$urandom, $urandom};
    return e;
  endfunction

  // Mix for running traffic: mostly pushes so the deque builds up,
  // grabs and steals to drain it, a few undefined codes as noise.
  function automatic logic [2:0] random_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return ACT_PUSH;
    if (r < 58) return ACT_EMPTY;
    if (r < 76) return ACT_GRAB;
    if (r < 94) return ACT_STEAL;
    return 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
  endfunction

  // One command transfer. Optional idle cycles first (start low), then start
  // stays high until an edge with busy low takes it. Called at a clock edge.
  task automatic issue_action(input logic [2:0] act, input entry_t e);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_task_id     <= e.task_id;
    in_price_word  <= e.price_word;
    in_volume_word <= e.volume_word;
    in_stamp       <= e.stamp;
    in_weight_word <= e.weight_word;
    do @(posedge clk); while (busy);
  endtask

  // Hold off new commands until every predicted result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (2) @(posedge clk);
  endtask

  // Config transfer, only with the block idle.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random running traffic; occasional long push runs push the deque deep,
  // occasional waits until every predicted result is back give the sender pauses.
  task automatic run_random(input int count);
    int         issued;
    int         run_len;
    logic [2:0] act;
    issued = 0;
    while (issued < count) begin
      if ($urandom_range(99) < 5) begin
        run_len = $urandom_range(8, 60);
        repeat (run_len) issue_action(ACT_PUSH, random_entry());
        issued += run_len;
      end else begin
        act = random_action();
        issue_action(act, random_entry());
        if (act < ACT_UNUSED_FIRST) issued++;
      end
      if ($urandom_range(99) < 2) wait_drained();
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part, reset config (watermark 16, batch limit 16) ---
    issue_action(ACT_GRAB, random_entry());     // empty deque, raises help
    issue_action(ACT_GRAB, random_entry());     // help already outstanding
    issue_action(ACT_STEAL, random_entry());    // nothing to steal
    issue_action(ACT_EMPTY, random_entry());    // clears the outstanding request
    // field extremes: most negative id and stamp with zero words, then the maximum
    issue_action(ACT_PUSH, {32'h8000_0000, 64'd0, 64'd0, 64'h8000_0000_0000_0000, 64'd0});
    issue_action(ACT_PUSH, {32'h7fff_ffff, {64{1'b1}}, {64{1'b1}},
                            64'h7fff_ffff_ffff_ffff, {64{1'b1}}});
    issue_action(ACT_PUSH, {32'haaaa_aaaa, {4{16'haaaa}}, {4{16'h5555}},
                            {4{16'haaaa}}, {4{16'h5555}}});
    issue_action(ACT_PUSH, {32'h5555_5555, {4{16'h5555}}, {4{16'haaaa}},
                            {4{16'h5555}}, {4{16'haaaa}}});
    issue_action(ACT_STEAL, random_entry());    // fill 4: two from the rear
    issue_action(ACT_GRAB, random_entry());     // remaining two, oldest first
    issue_action(ACT_PUSH, random_entry());
    issue_action(ACT_STEAL, random_entry());    // fill 1 rounds down to none
    issue_action(ACT_UNUSED_FIRST, random_entry());
    issue_action(ACT_UNUSED_MID, random_entry());
    issue_action(ACT_UNUSED_LAST, random_entry());
    issue_action(ACT_GRAB, random_entry());

    // --- random part, sender idles often ---
    write_reg(CFG_WATERMARK, CDAT_W'(128));
    write_reg(CFG_BATCH, CDAT_W'(1));
    run_random(50);
    write_reg(CFG_WATERMARK, CDAT_W'($urandom_range(1, 127)));
    write_reg(CFG_BATCH, CDAT_W'($urandom_range(2, 31)));
    run_random(50);

    // --- sender mostly idle ---
    sender_idle_pct = 73;
    write_reg(CFG_WATERMARK, CDAT_W'(0));
    write_reg(CFG_BATCH, CDAT_W'(32));
    run_random(50);
    write_reg(CFG_WATERMARK, CDAT_W'($urandom_range(1, 127)));
    write_reg(CFG_BATCH, CDAT_W'($urandom_range(2, 31)));
    run_random(50);

    // --- back to back; a long push run fills the deque and hits the drop path ---
    sender_idle_pct = 0;
    write_reg(CFG_WATERMARK, CDAT_W'($urandom_range(0, 128)));
    write_reg(CFG_BATCH, CDAT_W'($urandom_range(1, 32)));
    repeat (DEPTH + 6) issue_action(ACT_PUSH, random_entry());
    run_random(50);
    write_reg(CFG_WATERMARK, CDAT_W'(128));
    write_reg(CFG_BATCH, CDAT_W'(32));
    run_random(70);

    // --- stop: pushes, empties and steals are ignored, grabs still drain,
    //     and no help is raised once stopped ---
    sender_idle_pct = 13;
    repeat (3) issue_action(ACT_PUSH, random_entry());
    issue_action(ACT_STOP, random_entry());
    issue_action(ACT_PUSH, random_entry());
    issue_action(ACT_EMPTY, random_entry());
    issue_action(ACT_STEAL, random_entry());
    issue_action(ACT_UNUSED_LAST, random_entry());
    repeat (4) issue_action(ACT_GRAB, random_entry());
    issue_action(ACT_STOP, random_entry());     // stop while already stopped

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
